// ===== hw/rtl/tscc_pkg.sv =====
`default_nettype none

package tscc_pkg;

    localparam int BOX_SLOTS_DEF = 128;
    localparam int GROUP_SIZE    = 16;

    localparam logic [7:0] NO_COLOR = 8'd255;
    localparam logic [7:0] MAX_CODE = 8'd255;

    // divider widths: |numerator| < 2^23, |denominator| < 2^25, 16 fraction bits
    localparam int NUM_W     = 23;
    localparam int DEN_W     = 25;
    localparam int FRAC_BITS = 16;
    localparam int QUO_W     = NUM_W + FRAC_BITS;

    // cordic datapath widths
    localparam int CW           = 43;
    localparam int ZW           = 19;
    localparam int CORDIC_STEPS = 16;
    localparam int SAT_BIG_BIT  = 20;

    // color conversion coefficients, Q14
    localparam logic signed [26:0] KC_LUM = 27'sd71111;
    localparam logic signed [24:0] KR_U   = -25'sd10972;
    localparam logic signed [24:0] KR_V   = 25'sd27786;
    localparam logic signed [24:0] KG_U   = -25'sd19137;
    localparam logic signed [24:0] KG_V   = -25'sd22325;

    // angle to tint scale, Q16, and quadrant offsets, Q32
    localparam logic signed [22:0] KT_SCALE  = 23'sd2659749;
    localparam logic signed [43:0] T_OFF_POS = 44'sd273804165120;
    localparam logic signed [43:0] T_OFF_NEG = 44'sd821412495360;

    // magnitude to saturation scale, Q16
    localparam logic [23:0] KS_SCALE = 24'd13615261;

    typedef enum logic
    {
        OP_CLASSIFY = 1'b0,
        OP_LOAD     = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic [7:0] color;
        logic [7:0] t_lo;
        logic [7:0] t_hi;
        logic [7:0] s_lo;
        logic [7:0] s_hi;
        logic [7:0] l_lo;
        logic [7:0] l_hi;
    } box_t;

    typedef struct packed
    {
        opcode_t    opcode;
        logic [6:0] slot;
        box_t       box;
        logic [7:0] lum;
    } item_t;

    typedef struct packed
    {
        logic neg_r;
        logic neg_g;
        logic den_zero;
    } quo_sign_t;

    typedef struct packed
    {
        logic den_zero;
        logic g_zero;
        logic g_pos;
    } ang_flag_t;

    typedef struct packed
    {
        item_t      item;
        logic [7:0] tint;
        logic [7:0] sat;
        logic       found;
        logic [7:0] color;
    } cls_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int step);
        logic signed [ZW-1:0] a;
        case (step)
            0:       a = ZW'(51472);
            1:       a = ZW'(30386);
            2:       a = ZW'(16055);
            3:       a = ZW'(8150);
            4:       a = ZW'(4091);
            5:       a = ZW'(2047);
            6:       a = ZW'(1024);
            7:       a = ZW'(512);
            8:       a = ZW'(256);
            9:       a = ZW'(128);
            10:      a = ZW'(64);
            11:      a = ZW'(32);
            12:      a = ZW'(16);
            13:      a = ZW'(8);
            14:      a = ZW'(4);
            15:      a = ZW'(2);
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                      input logic [7:0] hi);
        return (lo <= v) && (v <= hi);
    endfunction

    // wrapped range when low is not below high
    function automatic logic in_tint(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
        logic r;
        if (lo < hi)
        begin
            r = (lo <= v) && (v <= hi);
        end
        else
        begin
            r = !((hi <= v) && (v <= lo));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/yuv_tsl_box_color_classifier_top.sv =====
// throughput: one beat per cycle while in_stall is low, classify and load alike; only classify beats give a result
// the pipeline is 41 divider stages, 19 cordic and scaling stages, one stage per 16 box slots
// reset clears all valid bits and box_count; box contents are undefined until loaded
`default_nettype none

module yuv_tsl_box_color_classifier_top #(
    parameter int BOX_SLOTS = tscc_pkg::BOX_SLOTS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    // input beat channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [0:0] opcode,
    input  wire logic [6:0] slot,
    input  wire logic [7:0] box_color,
    input  wire logic [7:0] tint_low,
    input  wire logic [7:0] tint_high,
    input  wire logic [7:0] sat_low,
    input  wire logic [7:0] sat_high,
    input  wire logic [7:0] lum_low,
    input  wire logic [7:0] lum_high,
    input  wire logic [7:0] pix_y,
    input  wire logic [7:0] pix_u,
    input  wire logic [7:0] pix_v,

    // result beat channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      color_index,
    output logic [7:0]      tint,
    output logic [7:0]      saturation,
    output logic            matched,

    // box_count register write
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    // whole pipeline moves together; it halts only while a result waits on a stall
    logic en;

    logic [7:0] box_count_reg;

    logic       out_vld_reg;
    logic [7:0] color_reg;
    logic [7:0] tint_reg;
    logic [7:0] sat_reg;
    logic       matched_reg;

    assign en        = !(out_vld_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            box_count_reg <= cfg_data;
        end
    end

    // input beat packed into the item that travels with the pixel
    tscc_pkg::item_t in_item;

    assign in_item.opcode    = tscc_pkg::opcode_t'(opcode);
    assign in_item.slot      = slot;
    assign in_item.box.color = box_color;
    assign in_item.box.t_lo  = tint_low;
    assign in_item.box.t_hi  = tint_high;
    assign in_item.box.s_lo  = sat_low;
    assign in_item.box.s_hi  = sat_high;
    assign in_item.box.l_lo  = lum_low;
    assign in_item.box.l_hi  = lum_high;
    assign in_item.lum       = pix_y;

    // chroma ratios: constant products, then bit-per-stage division
    logic                            div_vld;
    tscc_pkg::item_t                 div_item;
    logic [tscc_pkg::QUO_W-1:0]      div_quo_r;
    logic [tscc_pkg::QUO_W-1:0]      div_quo_g;
    tscc_pkg::quo_sign_t             div_sign;

    tscc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .in_item  (in_item),
        .pix_u    (pix_u),
        .pix_v    (pix_v),
        .out_vld  (div_vld),
        .out_item (div_item),
        .quo_r    (div_quo_r),
        .quo_g    (div_quo_g),
        .out_sign (div_sign)
    );

    // angle and magnitude, scaled to tint and saturation
    logic            cor_vld;
    tscc_pkg::item_t cor_item;
    logic [7:0]      cor_tint;
    logic [7:0]      cor_sat;

    tscc_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (div_vld),
        .in_item  (div_item),
        .quo_r    (div_quo_r),
        .quo_g    (div_quo_g),
        .in_sign  (div_sign),
        .out_vld  (cor_vld),
        .out_item (cor_item),
        .tint     (cor_tint),
        .sat      (cor_sat)
    );

    // box table and first-match search, one slot group per stage
    logic           box_vld;
    tscc_pkg::cls_t box_cls;

    tscc_boxes #(
        .BOX_SLOTS (BOX_SLOTS)
    ) u_boxes (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .box_count (box_count_reg),
        .in_vld    (cor_vld),
        .in_item   (cor_item),
        .tint      (cor_tint),
        .sat       (cor_sat),
        .out_vld   (box_vld),
        .out_cls   (box_cls)
    );

    // output register; load beats end here without a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= box_vld && (box_cls.item.opcode == tscc_pkg::OP_CLASSIFY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            color_reg   <= box_cls.found ? box_cls.color : tscc_pkg::NO_COLOR;
            tint_reg    <= box_cls.tint;
            sat_reg     <= box_cls.sat;
            matched_reg <= box_cls.found;
        end
    end

    assign out_valid   = out_vld_reg;
    assign color_index = color_reg;
    assign tint        = tint_reg;
    assign saturation  = sat_reg;
    assign matched     = matched_reg;

`ifndef SYNTHESIS
    a_match_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (matched_reg == (color_reg != tscc_pkg::NO_COLOR)))
        else $error("matched flag disagrees with color index");

    a_match_needs_boxes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && matched_reg) |-> (box_count_reg != 8'd0))
        else $error("match reported with no boxes in use");

    a_result_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(en))
        else $error("result appeared while the pipeline was halted");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tscc_div.sv =====
`default_nettype none

module tscc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire tscc_pkg::item_t               in_item,
    input  wire logic [7:0]                    pix_u,
    input  wire logic [7:0]                    pix_v,
    output logic                               out_vld,
    output tscc_pkg::item_t                    out_item,
    output logic [tscc_pkg::QUO_W-1:0]         quo_r,
    output logic [tscc_pkg::QUO_W-1:0]         quo_g,
    output tscc_pkg::quo_sign_t                out_sign
);

    localparam int NW = tscc_pkg::NUM_W;
    localparam int DW = tscc_pkg::DEN_W;
    localparam int QW = tscc_pkg::QUO_W;

    // products stage
    logic signed [8:0]  du;
    logic signed [8:0]  dv;
    logic signed [10:0] ch_sum;
    logic signed [26:0] lum_s;
    logic signed [26:0] c_next;
    logic signed [24:0] du_w;
    logic signed [24:0] dv_w;
    logic signed [24:0] nr_next;
    logic signed [24:0] ng_next;

    logic signed [26:0] c_reg;
    logic signed [24:0] nr_reg;
    logic signed [24:0] ng_reg;
    tscc_pkg::item_t    item1_reg;
    logic               vld1_reg;

    assign du      = $signed({1'b0, pix_u}) - 9'sd128;
    assign dv      = $signed({1'b0, pix_v}) - 9'sd128;
    assign ch_sum  = 11'(du) + 11'(du) + 11'(dv);
    assign lum_s   = 27'({1'b0, in_item.lum});
    assign c_next  = lum_s * tscc_pkg::KC_LUM + (27'(ch_sum) <<< 14);
    assign du_w    = 25'(du);
    assign dv_w    = 25'(dv);
    assign nr_next = du_w * tscc_pkg::KR_U + dv_w * tscc_pkg::KR_V;
    assign ng_next = du_w * tscc_pkg::KG_U + dv_w * tscc_pkg::KG_V;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg     <= c_next;
            nr_reg    <= nr_next;
            ng_reg    <= ng_next;
            item1_reg <= in_item;
        end
    end

    // magnitude stage, then one quotient bit per stage
    logic [DW-1:0]       rem_r_reg [QW+1];
    logic [DW-1:0]       rem_g_reg [QW+1];
    logic [QW-1:0]       sr_r_reg  [QW+1];
    logic [QW-1:0]       sr_g_reg  [QW+1];
    logic [DW-1:0]       den_reg   [QW+1];
    tscc_pkg::quo_sign_t sign_reg  [QW+1];
    tscc_pkg::item_t     item_reg  [QW+1];
    logic                vld_reg   [QW+1];

    logic signed [26:0]  c_abs;
    logic signed [24:0]  nr_abs;
    logic signed [24:0]  ng_abs;
    tscc_pkg::quo_sign_t sign_next;

    assign c_abs  = c_reg[26]  ? -c_reg  : c_reg;
    assign nr_abs = nr_reg[24] ? -nr_reg : nr_reg;
    assign ng_abs = ng_reg[24] ? -ng_reg : ng_reg;

    assign sign_next.neg_r    = nr_reg[24] ^ c_reg[26];
    assign sign_next.neg_g    = ng_reg[24] ^ c_reg[26];
    assign sign_next.den_zero = (c_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_r_reg[0] <= '0;
            rem_g_reg[0] <= '0;
            sr_r_reg[0]  <= {nr_abs[NW-1:0], tscc_pkg::FRAC_BITS'(0)};
            sr_g_reg[0]  <= {ng_abs[NW-1:0], tscc_pkg::FRAC_BITS'(0)};
            den_reg[0]   <= c_abs[DW-1:0];
            sign_reg[0]  <= sign_next;
            item_reg[0]  <= item1_reg;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW:0] tr;
        logic [DW:0] tg;
        logic [DW:0] dd;
        logic        ge_r;
        logic        ge_g;

        assign dd   = {1'b0, den_reg[k]};
        assign tr   = {rem_r_reg[k], sr_r_reg[k][QW-1]};
        assign tg   = {rem_g_reg[k], sr_g_reg[k][QW-1]};
        assign ge_r = (tr >= dd);
        assign ge_g = (tg >= dd);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_r_reg[k+1] <= ge_r ? DW'(tr - dd) : tr[DW-1:0];
                rem_g_reg[k+1] <= ge_g ? DW'(tg - dd) : tg[DW-1:0];
                sr_r_reg[k+1]  <= {sr_r_reg[k][QW-2:0], ge_r};
                sr_g_reg[k+1]  <= {sr_g_reg[k][QW-2:0], ge_g};
                den_reg[k+1]   <= den_reg[k];
                sign_reg[k+1]  <= sign_reg[k];
                item_reg[k+1]  <= item_reg[k];
            end
        end
    end

    assign out_vld  = vld_reg[QW];
    assign out_item = item_reg[QW];
    assign quo_r    = sr_r_reg[QW];
    assign quo_g    = sr_g_reg[QW];
    assign out_sign = sign_reg[QW];

endmodule

`default_nettype wire

// ===== hw/rtl/tscc_cordic.sv =====
`default_nettype none

module tscc_cordic (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire tscc_pkg::item_t               in_item,
    input  wire logic [tscc_pkg::QUO_W-1:0]    quo_r,
    input  wire logic [tscc_pkg::QUO_W-1:0]    quo_g,
    input  wire tscc_pkg::quo_sign_t           in_sign,
    output logic                               out_vld,
    output tscc_pkg::item_t                    out_item,
    output logic [7:0]                         tint,
    output logic [7:0]                         sat
);

    localparam int CW = tscc_pkg::CW;
    localparam int ZW = tscc_pkg::ZW;
    localparam int NS = tscc_pkg::CORDIC_STEPS;

    logic signed [CW-1:0] x_reg    [NS+1];
    logic signed [CW-1:0] y_reg    [NS+1];
    logic signed [ZW-1:0] z_reg    [NS+1];
    tscc_pkg::ang_flag_t  flag_reg [NS+1];
    tscc_pkg::item_t      item_reg [NS+1];
    logic                 vld_reg  [NS+1];

    // start vector: x = |g|, y = r with the sign of g folded in
    logic                 g_zero;
    logic                 g_neg;
    logic signed [CW-1:0] r_mag;
    tscc_pkg::ang_flag_t  flag_next;

    assign g_zero = (quo_g == '0);
    assign g_neg  = in_sign.neg_g && !g_zero;
    assign r_mag  = CW'(quo_r);

    assign flag_next.den_zero = in_sign.den_zero;
    assign flag_next.g_zero   = g_zero;
    assign flag_next.g_pos    = !g_zero && !in_sign.neg_g;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CW'(quo_g);
            y_reg[0]    <= (in_sign.neg_r ^ g_neg) ? -r_mag : r_mag;
            z_reg[0]    <= '0;
            flag_reg[0] <= flag_next;
            item_reg[0] <= in_item;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - tscc_pkg::atan_q16(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + tscc_pkg::atan_q16(i);
                end
                flag_reg[i+1] <= flag_reg[i];
                item_reg[i+1] <= item_reg[i];
            end
        end
    end

    // scale stage
    logic signed [41:0]   tprod_next;
    logic [19:0]          x_low;
    logic [43:0]          sprod_next;
    logic signed [41:0]   tprod_reg;
    logic [43:0]          sprod_reg;
    logic                 xbig_reg;
    tscc_pkg::ang_flag_t  flag_p_reg;
    tscc_pkg::item_t      item_p_reg;
    logic                 vld_p_reg;

    assign x_low      = x_reg[NS][19:0];
    assign tprod_next = z_reg[NS] * tscc_pkg::KT_SCALE;
    assign sprod_next = x_low * tscc_pkg::KS_SCALE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_p_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_p_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tprod_reg  <= tprod_next;
            sprod_reg  <= sprod_next;
            xbig_reg   <= |x_reg[NS][CW-1:tscc_pkg::SAT_BIG_BIT];
            flag_p_reg <= flag_reg[NS];
            item_p_reg <= item_reg[NS];
        end
    end

    // offset and clamp stage
    logic signed [43:0] s_sum;
    logic [7:0]         tint_next;
    logic [7:0]         sat_next;
    logic [7:0]         tint_reg;
    logic [7:0]         sat_reg;
    tscc_pkg::item_t    item_q_reg;
    logic               vld_q_reg;

    assign s_sum = 44'(tprod_reg) +
                   (flag_p_reg.g_pos ? tscc_pkg::T_OFF_POS : tscc_pkg::T_OFF_NEG);

    always_comb
    begin
        if (flag_p_reg.den_zero || flag_p_reg.g_zero || s_sum[43])
        begin
            tint_next = '0;
        end
        else if (|s_sum[42:40])
        begin
            tint_next = tscc_pkg::MAX_CODE;
        end
        else
        begin
            tint_next = s_sum[39:32];
        end

        if (flag_p_reg.den_zero || xbig_reg || (|sprod_reg[43:40]))
        begin
            sat_next = tscc_pkg::MAX_CODE;
        end
        else
        begin
            sat_next = sprod_reg[39:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_q_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_q_reg <= vld_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tint_reg   <= tint_next;
            sat_reg    <= sat_next;
            item_q_reg <= item_p_reg;
        end
    end

    assign out_vld  = vld_q_reg;
    assign out_item = item_q_reg;
    assign tint     = tint_reg;
    assign sat      = sat_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tscc_boxes.sv =====
`default_nettype none

module tscc_boxes #(
    parameter int BOX_SLOTS = tscc_pkg::BOX_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [7:0]         box_count,
    input  wire logic               in_vld,
    input  wire tscc_pkg::item_t    in_item,
    input  wire logic [7:0]         tint,
    input  wire logic [7:0]         sat,
    output logic                    out_vld,
    output tscc_pkg::cls_t          out_cls
);

    localparam int GS         = tscc_pkg::GROUP_SIZE;
    localparam int NUM_GROUPS = (BOX_SLOTS + GS - 1) / GS;

    logic           st_vld [NUM_GROUPS+1];
    tscc_pkg::cls_t st_cls [NUM_GROUPS+1];

    assign st_vld[0]           = in_vld;
    assign st_cls[0].item      = in_item;
    assign st_cls[0].tint      = tint;
    assign st_cls[0].sat       = sat;
    assign st_cls[0].found     = 1'b0;
    assign st_cls[0].color     = tscc_pkg::NO_COLOR;

    // each stage owns one group of slots; loads write their slot as they pass
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_grp
        localparam int BASE = g * GS;
        localparam int SIZE = ((BOX_SLOTS - BASE) < GS) ? (BOX_SLOTS - BASE) : GS;

        logic [SIZE-1:0] hit;
        logic [7:0]      col [SIZE];
        logic [7:0]      hit_color;
        logic            is_load;
        tscc_pkg::cls_t  cls_next;
        tscc_pkg::cls_t  cls_reg;
        logic            vld_reg;

        assign is_load = (st_cls[g].item.opcode == tscc_pkg::OP_LOAD);

        for (genvar i = 0; i < SIZE; i++)
        begin : g_box
            localparam logic [8:0] IDX = 9'(BASE + i);

            tscc_pkg::box_t box_reg;
            logic           wr;

            assign wr = en && st_vld[g] && is_load && ({2'b00, st_cls[g].item.slot} == IDX);

            always_ff @(posedge clk)
            begin
                if (wr)
                begin
                    box_reg <= st_cls[g].item.box;
                end
            end

            assign col[i] = box_reg.color;
            assign hit[i] = (IDX < {1'b0, box_count}) &&
                            tscc_pkg::in_tint(st_cls[g].tint, box_reg.t_lo, box_reg.t_hi) &&
                            tscc_pkg::in_range(st_cls[g].sat, box_reg.s_lo, box_reg.s_hi) &&
                            tscc_pkg::in_range(st_cls[g].item.lum, box_reg.l_lo, box_reg.l_hi) &&
                            (box_reg.color != tscc_pkg::NO_COLOR);
        end

        // lowest slot wins
        always_comb
        begin
            hit_color = tscc_pkg::NO_COLOR;
            for (int i = SIZE - 1; i >= 0; i--)
            begin
                if (hit[i])
                begin
                    hit_color = col[i];
                end
            end

            cls_next = st_cls[g];
            if (!is_load && !st_cls[g].found && (|hit))
            begin
                cls_next.found = 1'b1;
                cls_next.color = hit_color;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= st_vld[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cls_reg <= cls_next;
            end
        end

        assign st_vld[g+1] = vld_reg;
        assign st_cls[g+1] = cls_reg;
    end

    assign out_vld = st_vld[NUM_GROUPS];
    assign out_cls = st_cls[NUM_GROUPS];

endmodule

`default_nettype wire
